/* design/mfc_pkg.sv */
// Shared types, constants and helpers for the magnetometer field correction block.
package mfc_pkg;

  localparam int RAW_W   = 16;
  localparam int ASA_W   = 8;
  localparam int FIELD_W = 24;
  localparam int COEF_W  = 16;
  localparam int GAIN_W  = 25;
  localparam int SCALE_W = 38;
  localparam int SHIFT_S = 16;
  localparam int CORR_W  = 23;
  localparam int TERM_W  = 39;
  localparam int SUM_W   = 41;
  localparam int SHIFT_M = 14;
  localparam int ROW_W   = 27;
  localparam int SIGN_W  = 28;

  localparam logic [8:0]  ASA_OFFSET = 9'd128;
  localparam logic [13:0] SCALE_MUL  = 14'd9830;
  localparam int READY_BIT   = 0;
  localparam int OVERRUN_BIT = 3;

  localparam logic [2:0] CFG_SENS_ADJUST    = 3'd0;
  localparam logic [2:0] CFG_HARD_IRON_BIAS = 3'd1;
  localparam logic [2:0] CFG_SOFT_IRON_DIAG = 3'd2;
  localparam logic [2:0] CFG_SOFT_IRON_OFF  = 3'd3;
  localparam logic [2:0] CFG_NED_TO_ENU     = 3'd4;

  localparam logic [23:0] SENS_ADJUST_RST = 24'h808080;
  localparam logic [47:0] HARD_IRON_RST   = 48'h0;
  localparam logic [47:0] SOFT_DIAG_RST   = 48'h400040004000;
  localparam logic [47:0] SOFT_OFF_RST    = 48'h0;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_NOT_READY = 2'd1,
    RC_BUS_ERROR = 2'd2,
    RC_OVERRUN   = 2'd3
  } result_code_e;

  typedef struct packed {
    logic [7:0]         status_one;
    logic               bus_error;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic [7:0]         status_two;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_code;
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic signed [23:0] field_z;
  } out_item_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
    logic s5_en;
    logic out_en;
  } pipe_ctrl_t;

  function automatic logic signed [FIELD_W-1:0] sat24(input logic signed [SIGN_W-1:0] v);
    logic hi_same;
    hi_same = (v[SIGN_W-1:FIELD_W-1] == '0) || (v[SIGN_W-1:FIELD_W-1] == '1);
    if (hi_same) begin
      return v[FIELD_W-1:0];
    end else if (v[SIGN_W-1]) begin
      return {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(FIELD_W-1){1'b1}}};
    end
  endfunction

endpackage

/* design/mfc_scale_lane.sv */
// One axis lane: sensitivity and unit scaling followed by hard-iron bias removal.
module mfc_scale_lane (
  input  logic                                 clk_i,
  input  mfc_pkg::pipe_ctrl_t                  ctrl_i,
  input  logic signed [mfc_pkg::RAW_W-1:0]     raw_i,
  input  logic [mfc_pkg::ASA_W-1:0]            asa_i,
  input  logic signed [mfc_pkg::COEF_W-1:0]    bias_i,
  output logic signed [mfc_pkg::CORR_W-1:0]    corr_o
);

  logic [8:0]                                 asa_plus;
  logic signed [mfc_pkg::GAIN_W:0]            gain_full;
  logic signed [mfc_pkg::GAIN_W-1:0]          gain_d, gain_q;
  logic signed [mfc_pkg::GAIN_W+14:0]         scale_full;
  logic signed [mfc_pkg::SCALE_W-1:0]         scale_d, scale_q;
  logic signed [mfc_pkg::SCALE_W-mfc_pkg::SHIFT_S-1:0] scaled;
  logic signed [mfc_pkg::CORR_W-1:0]          corr_d, corr_q;

  assign asa_plus   = {1'b0, asa_i} + mfc_pkg::ASA_OFFSET;
  assign gain_full  = raw_i * $signed({1'b0, asa_plus});
  assign gain_d     = gain_full[mfc_pkg::GAIN_W-1:0];
  assign scale_full = gain_q * $signed({1'b0, mfc_pkg::SCALE_MUL});
  assign scale_d    = scale_full[mfc_pkg::SCALE_W-1:0];
  assign scaled     = scale_q[mfc_pkg::SCALE_W-1:mfc_pkg::SHIFT_S];
  assign corr_d     = {scaled[$high(scaled)], scaled}
                      - {{(mfc_pkg::CORR_W-mfc_pkg::COEF_W){bias_i[mfc_pkg::COEF_W-1]}}, bias_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      gain_q <= gain_d;
    end
    if (ctrl_i.s2_en) begin
      scale_q <= scale_d;
    end
    if (ctrl_i.s3_en) begin
      corr_q <= corr_d;
    end
  end

  assign corr_o = corr_q;

endmodule

/* design/mfc_matrix_lane.sv */
// One row of the soft-iron matrix: three products, then the sum scaled down by 2^14.
module mfc_matrix_lane (
  input  logic                               clk_i,
  input  mfc_pkg::pipe_ctrl_t                ctrl_i,
  input  logic signed [mfc_pkg::CORR_W-1:0]  c0_i,
  input  logic signed [mfc_pkg::CORR_W-1:0]  c1_i,
  input  logic signed [mfc_pkg::CORR_W-1:0]  c2_i,
  input  logic signed [mfc_pkg::COEF_W-1:0]  k0_i,
  input  logic signed [mfc_pkg::COEF_W-1:0]  k1_i,
  input  logic signed [mfc_pkg::COEF_W-1:0]  k2_i,
  output logic signed [mfc_pkg::ROW_W-1:0]   row_o
);

  logic signed [mfc_pkg::TERM_W-1:0] t0_d, t1_d, t2_d;
  logic signed [mfc_pkg::TERM_W-1:0] t0_q, t1_q, t2_q;
  logic signed [mfc_pkg::SUM_W-1:0]  sum;
  logic signed [mfc_pkg::ROW_W-1:0]  row_d, row_q;

  assign t0_d = c0_i * k0_i;
  assign t1_d = c1_i * k1_i;
  assign t2_d = c2_i * k2_i;

  assign sum = {{2{t0_q[mfc_pkg::TERM_W-1]}}, t0_q}
             + {{2{t1_q[mfc_pkg::TERM_W-1]}}, t1_q}
             + {{2{t2_q[mfc_pkg::TERM_W-1]}}, t2_q};
  assign row_d = sum[mfc_pkg::SUM_W-1:mfc_pkg::SHIFT_M];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s4_en) begin
      t0_q <= t0_d;
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
    if (ctrl_i.s5_en) begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

/* design/mfc_merge.sv */
// Merging stage: axis remap, saturation, status gating and the output register.
module mfc_merge (
  input  logic                              clk_i,
  input  mfc_pkg::pipe_ctrl_t               ctrl_i,
  input  mfc_pkg::result_code_e             code_i,
  input  logic                              ned_i,
  input  logic signed [mfc_pkg::ROW_W-1:0]  m0_i,
  input  logic signed [mfc_pkg::ROW_W-1:0]  m1_i,
  input  logic signed [mfc_pkg::ROW_W-1:0]  m2_i,
  output mfc_pkg::out_item_t                item_o
);

  logic signed [mfc_pkg::SIGN_W-1:0] ex, ey, ez, zneg;
  logic signed [mfc_pkg::SIGN_W-1:0] ax, ay, az;
  mfc_pkg::out_item_t                item_d, item_q;

  assign ex   = {m0_i[mfc_pkg::ROW_W-1], m0_i};
  assign ey   = {m1_i[mfc_pkg::ROW_W-1], m1_i};
  assign ez   = {m2_i[mfc_pkg::ROW_W-1], m2_i};
  assign zneg = {mfc_pkg::SIGN_W{1'b0}} - ez;

  always_comb begin
    if (ned_i) begin
      ax = ey;
      ay = ex;
      az = zneg;
    end else begin
      ax = ex;
      ay = ey;
      az = ez;
    end
    item_d.result_code = code_i;
    if (code_i == mfc_pkg::RC_OK) begin
      item_d.field_x = mfc_pkg::sat24(ax);
      item_d.field_y = mfc_pkg::sat24(ay);
      item_d.field_z = mfc_pkg::sat24(az);
    end else begin
      item_d.field_x = '0;
      item_d.field_y = '0;
      item_d.field_z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

/* design/magnetometer_field_correction.sv */
// Top level of the magnetometer field correction block: config registers and pipeline control.
// Throughput: one item per cycle while the output is not stalled; three axis lanes and three
// matrix row lanes run side by side. The pipeline holds up to six items; a stalled output
// freezes the stages only as far back as they are full. Reset clears the valid bits and
// loads the calibration registers with unity sensitivity, zero bias, an identity soft-iron
// matrix and NED output.
module magnetometer_field_correction (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mfc_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mfc_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i
);

  logic [23:0] sens_q;
  logic [47:0] bias_q, diag_q, off_q;
  logic        ned_q;

  logic [5:1]  vld_q;
  logic        out_vld_q;
  logic [6:1]  adv;
  mfc_pkg::pipe_ctrl_t   ctrl;
  mfc_pkg::result_code_e code_d;
  mfc_pkg::result_code_e code_q [5];

  logic signed [mfc_pkg::CORR_W-1:0] cx, cy, cz;
  logic signed [mfc_pkg::ROW_W-1:0]  mx, my, mz;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= mfc_pkg::SENS_ADJUST_RST;
      bias_q <= mfc_pkg::HARD_IRON_RST;
      diag_q <= mfc_pkg::SOFT_DIAG_RST;
      off_q  <= mfc_pkg::SOFT_OFF_RST;
      ned_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mfc_pkg::CFG_SENS_ADJUST:    sens_q <= cfg_data_i[23:0];
        mfc_pkg::CFG_HARD_IRON_BIAS: bias_q <= cfg_data_i;
        mfc_pkg::CFG_SOFT_IRON_DIAG: diag_q <= cfg_data_i;
        mfc_pkg::CFG_SOFT_IRON_OFF:  off_q  <= cfg_data_i;
        mfc_pkg::CFG_NED_TO_ENU:     ned_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign adv[6] = !out_vld_q || !out_stall_i;
  assign adv[5] = !vld_q[5] || adv[6];
  assign adv[4] = !vld_q[4] || adv[5];
  assign adv[3] = !vld_q[3] || adv[4];
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];

  assign ctrl.s1_en  = adv[1];
  assign ctrl.s2_en  = adv[2];
  assign ctrl.s3_en  = adv[3];
  assign ctrl.s4_en  = adv[4];
  assign ctrl.s5_en  = adv[5];
  assign ctrl.out_en = adv[6];

  assign in_stall_o  = !adv[1];
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv[1]) begin
        vld_q[1] <= in_valid_i;
      end
      if (adv[2]) begin
        vld_q[2] <= vld_q[1];
      end
      if (adv[3]) begin
        vld_q[3] <= vld_q[2];
      end
      if (adv[4]) begin
        vld_q[4] <= vld_q[3];
      end
      if (adv[5]) begin
        vld_q[5] <= vld_q[4];
      end
      if (adv[6]) begin
        out_vld_q <= vld_q[5];
      end
    end
  end

  always_comb begin
    if (!in_item_i.status_one[mfc_pkg::READY_BIT]) begin
      code_d = mfc_pkg::RC_NOT_READY;
    end else if (in_item_i.bus_error) begin
      code_d = mfc_pkg::RC_BUS_ERROR;
    end else if (in_item_i.status_two[mfc_pkg::OVERRUN_BIT]) begin
      code_d = mfc_pkg::RC_OVERRUN;
    end else begin
      code_d = mfc_pkg::RC_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      code_q[0] <= code_d;
    end
    if (adv[2]) begin
      code_q[1] <= code_q[0];
    end
    if (adv[3]) begin
      code_q[2] <= code_q[1];
    end
    if (adv[4]) begin
      code_q[3] <= code_q[2];
    end
    if (adv[5]) begin
      code_q[4] <= code_q[3];
    end
  end

  mfc_scale_lane u_scale_x (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .raw_i  (in_item_i.raw_x),
    .asa_i  (sens_q[7:0]),
    .bias_i (bias_q[15:0]),
    .corr_o (cx)
  );

  mfc_scale_lane u_scale_y (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .raw_i  (in_item_i.raw_y),
    .asa_i  (sens_q[15:8]),
    .bias_i (bias_q[31:16]),
    .corr_o (cy)
  );

  mfc_scale_lane u_scale_z (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .raw_i  (in_item_i.raw_z),
    .asa_i  (sens_q[23:16]),
    .bias_i (bias_q[47:32]),
    .corr_o (cz)
  );

  mfc_matrix_lane u_row_x (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .c0_i   (cx),
    .c1_i   (cy),
    .c2_i   (cz),
    .k0_i   (diag_q[15:0]),
    .k1_i   (off_q[15:0]),
    .k2_i   (off_q[31:16]),
    .row_o  (mx)
  );

  mfc_matrix_lane u_row_y (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .c0_i   (cx),
    .c1_i   (cy),
    .c2_i   (cz),
    .k0_i   (off_q[15:0]),
    .k1_i   (diag_q[31:16]),
    .k2_i   (off_q[47:32]),
    .row_o  (my)
  );

  mfc_matrix_lane u_row_z (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .c0_i   (cx),
    .c1_i   (cy),
    .c2_i   (cz),
    .k0_i   (off_q[31:16]),
    .k1_i   (off_q[47:32]),
    .k2_i   (diag_q[47:32]),
    .row_o  (mz)
  );

  mfc_merge u_merge (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .code_i (code_q[4]),
    .ned_i  (ned_q),
    .m0_i   (mx),
    .m1_i   (my),
    .m2_i   (mz),
    .item_o (out_item_o)
  );

endmodule
